### src/bdpt_pkg.sv
// Package for the button debounce and press timer block.
// Holds pin mask, register indexes, reset values and shared widths; no dependencies.
`default_nettype none

package bdpt_pkg;

	// Pin count of the sampled port and the pins that carry buttons.
	localparam int unsigned PIN_COUNT = 16;
	localparam logic [PIN_COUNT-1:0] PIN_MASK = 16'h1F1F;

	// Pins at or above this index belong to the second column.
	localparam int unsigned PIN_SPLIT = 8;

	// Widths of the payload and register fields.
	localparam int unsigned TIME_W = 32;
	localparam int unsigned COL_W = 8;
	localparam int unsigned ROW_W = 3;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLL_INTERVAL = 2'd0,
		CFG_DEBOUNCE_TIME = 2'd1,
		CFG_FIRST_COLUMN  = 2'd2
	} cfg_idx_t;

	// Register values after reset.
	localparam logic [15:0] POLL_INTERVAL_RST = 16'd10;
	localparam logic [15:0] DEBOUNCE_TIME_RST = 16'd30;
	localparam logic [COL_W-1:0] FIRST_COLUMN_RST = 8'd0;

	// One button coordinate.
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
	} coord_t;

endpackage

`default_nettype wire

### src/button_debounce_press_timer.sv
// Top level of the button debounce and press timer block.
// Depends on bdpt_pkg for constants, register indexes and the coordinate type.
`default_nettype none

// Takes one timestamped sample of a 16-pin active-low port per transfer and returns
// exactly one result per sample. A new sample can be taken in every clock cycle while
// the result side does not stall. The sample first lands in an input register, then the
// poll and debounce checks and the scan over the ten button pins run in one pass of
// logic into the result register, from which the result is presented. While the result
// side stalls, the input register holds one more sample and then the input stalls.
// Configuration writes are taken in any cycle and must only happen while no sample
// is in flight. Column and row of an idle coordinate read as zero, and the duration
// is zero unless a press is being timed or has just ended.
module button_debounce_press_timer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write port.
	input  wire logic                          cfg_we,
	input  wire logic [bdpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bdpt_pkg::CFG_W-1:0]     cfg_data,
	// Input channel.
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [bdpt_pkg::TIME_W-1:0]    time_ms,
	input  wire logic [15:0]                   gpio_levels,
	input  wire logic                          read_ok,
	// Output channel.
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               held_valid,
	output logic [bdpt_pkg::COL_W-1:0]          held_column,
	output logic [bdpt_pkg::ROW_W-1:0]          held_row,
	output logic                               released_valid,
	output logic [bdpt_pkg::COL_W-1:0]          released_column,
	output logic [bdpt_pkg::ROW_W-1:0]          released_row,
	output logic [bdpt_pkg::TIME_W-1:0]         duration_ms
);
	import bdpt_pkg::*;

	// Configuration registers.
	logic [15:0]      poll_interval_q;
	logic [15:0]      debounce_time_q;
	logic [COL_W-1:0] first_column_q;

	// Debounce and press tracking state.
	logic [PIN_COUNT-1:0] raw_sample_q;
	logic [PIN_COUNT-1:0] stable_sample_q;
	logic [TIME_W-1:0]    last_poll_time_q;
	logic [TIME_W-1:0]    last_change_time_q;
	logic                 pressed_valid_q;
	coord_t               pressed_q;
	logic [TIME_W-1:0]    press_start_time_q;

	// Input register.
	logic                 valid_s1;
	logic [TIME_W-1:0]    time_s1;
	logic [15:0]          levels_s1;
	logic                 ok_s1;

	// Result register.
	logic                 out_valid_q;
	logic                 held_valid_q;
	coord_t               held_q;
	logic                 released_valid_q;
	coord_t               released_q;
	logic [TIME_W-1:0]    duration_q;

	// Handshake control.
	logic in_xfer;
	logic s1_go;

	// Single-pass evaluation signals.
	logic [TIME_W-1:0]    since_poll;
	logic [TIME_W-1:0]    since_change;
	logic [TIME_W-1:0]    since_press;
	logic                 poll_due;
	logic                 sampled;
	logic [PIN_COUNT-1:0] sample;
	logic                 changed;
	logic                 steady;
	logic                 upd;
	logic                 hold_report;
	logic [PIN_COUNT-1:0] pressed_bits;
	logic [PIN_COUNT-1:0] released_bits;
	logic                 scan_hv;
	coord_t               scan_held;
	logic                 scan_rv;
	coord_t               scan_released;
	logic                 scan_pv;
	coord_t               scan_pressed;
	logic                 scan_fresh;
	logic                 scan_dur_old;
	coord_t               pin_c;
	logic                 res_hv;
	coord_t               res_held;
	logic                 res_rv;
	coord_t               res_released;
	logic [TIME_W-1:0]    res_dur;

	// The input register moves on whenever the result register is free or draining.
	assign s1_go    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_go;
	assign in_xfer  = in_valid && !in_stall;

	// Configuration writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_interval_q <= POLL_INTERVAL_RST;
			debounce_time_q <= DEBOUNCE_TIME_RST;
			first_column_q  <= FIRST_COLUMN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLL_INTERVAL: poll_interval_q <= cfg_data;
				CFG_DEBOUNCE_TIME: debounce_time_q <= cfg_data;
				CFG_FIRST_COLUMN:  first_column_q  <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: valid bit under reset, payload loads on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			time_s1   <= time_ms;
			levels_s1 <= gpio_levels;
			ok_s1     <= read_ok;
		end
	end

	// Poll and debounce checks with wrapping time differences.
	always_comb begin
		since_poll   = time_s1 - last_poll_time_q;
		since_change = time_s1 - last_change_time_q;
		since_press  = time_s1 - press_start_time_q;
		poll_due     = since_poll >= {{(TIME_W-16){1'b0}}, poll_interval_q};
		sampled      = poll_due && ok_s1;
		sample       = ~levels_s1 & PIN_MASK;
		changed      = sample != raw_sample_q;
		steady       = since_change >= {{(TIME_W-16){1'b0}}, debounce_time_q};
		upd          = sampled && !changed && steady && (stable_sample_q != raw_sample_q);
		hold_report  = sampled && !changed && steady && (stable_sample_q == raw_sample_q)
			&& pressed_valid_q;
		pressed_bits  = raw_sample_q & ~stable_sample_q & PIN_MASK;
		released_bits = stable_sample_q & ~raw_sample_q & PIN_MASK;
	end

	// Ascending scan over the button pins; later pins overwrite earlier reports.
	// A fresh press restarts the timer at the current time, so a release that
	// matches it in the same scan reports zero duration.
	always_comb begin
		scan_hv       = 1'b0;
		scan_held     = '0;
		scan_rv       = 1'b0;
		scan_released = '0;
		scan_pv       = pressed_valid_q;
		scan_pressed  = pressed_q;
		scan_fresh    = 1'b0;
		scan_dur_old  = 1'b0;
		pin_c         = '0;
		for (int i = 0; i < PIN_COUNT; i++) begin
			if (PIN_MASK[i]) begin
				if (i < PIN_SPLIT) begin
					pin_c.column = first_column_q;
					pin_c.row    = ROW_W'(i);
				end else begin
					pin_c.column = first_column_q + COL_W'(1);
					pin_c.row    = ROW_W'(i - PIN_SPLIT);
				end
				if (pressed_bits[i]) begin
					scan_pv      = 1'b1;
					scan_pressed = pin_c;
					scan_fresh   = 1'b1;
					scan_hv      = 1'b1;
					scan_held    = pin_c;
					scan_dur_old = 1'b0;
				end
				if (released_bits[i]) begin
					scan_rv       = 1'b1;
					scan_released = pin_c;
					if (scan_pv && (pin_c == scan_pressed)) begin
						scan_dur_old = !scan_fresh;
						scan_pv      = 1'b0;
						scan_pressed = '0;
					end
				end
			end
		end
	end

	// Result selection: scan outcome, held report, or all zero.
	always_comb begin
		res_hv       = 1'b0;
		res_held     = '0;
		res_rv       = 1'b0;
		res_released = '0;
		res_dur      = '0;
		if (upd) begin
			res_hv       = scan_hv;
			res_held     = scan_held;
			res_rv       = scan_rv;
			res_released = scan_released;
			res_dur      = scan_dur_old ? since_press : '0;
		end else if (hold_report) begin
			res_hv   = 1'b1;
			res_held = pressed_q;
			res_dur  = since_press;
		end
	end

	// State update when the sample leaves the input register and a poll is due.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_sample_q       <= '0;
			stable_sample_q    <= '0;
			last_poll_time_q   <= '0;
			last_change_time_q <= '0;
			pressed_valid_q    <= 1'b0;
			pressed_q          <= '0;
			press_start_time_q <= '0;
		end else if (s1_go && poll_due) begin
			last_poll_time_q <= time_s1;
			if (ok_s1 && changed) begin
				raw_sample_q       <= sample;
				last_change_time_q <= time_s1;
			end
			if (upd) begin
				stable_sample_q <= raw_sample_q;
				pressed_valid_q <= scan_pv;
				pressed_q       <= scan_pressed;
				if (scan_fresh) begin
					press_start_time_q <= time_s1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			held_valid_q     <= res_hv;
			held_q           <= res_held;
			released_valid_q <= res_rv;
			released_q       <= res_released;
			duration_q       <= res_dur;
		end
	end

	assign out_valid       = out_valid_q;
	assign held_valid      = held_valid_q;
	assign held_column     = held_q.column;
	assign held_row        = held_q.row;
	assign released_valid  = released_valid_q;
	assign released_column = released_q.column;
	assign released_row    = released_q.row;
	assign duration_ms     = duration_q;

	// A sample in the input register reaches an empty result register next cycle.
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid)
		else $error("sample did not reach the result register");

	// The input side only stalls while it holds a sample.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	// A nonzero duration always comes with a reported button.
	a_dur_with_button: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && duration_ms != '0) |-> (held_valid || released_valid))
		else $error("duration reported without a button");

	// No tracked press leaves a cleared coordinate.
	a_idle_coord: assert property (@(posedge clk) disable iff (!arst_n)
		!pressed_valid_q |-> (pressed_q == '0))
		else $error("tracked coordinate set without a press");

	// The stable state changes only on a debounced update.
	a_stable_only_on_upd: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_go && poll_due && upd) |=> $stable(stable_sample_q))
		else $error("stable state changed without a debounced update");

endmodule

`default_nettype wire
